/* src/fvdi_pkg.sv */
// Shared constants and types for the face vertex dedup indexer.
package fvdi_pkg;

    localparam int MaxVertices = 4096;
    localparam int IndexBits   = 32;
    localparam int VnumBits    = $clog2(MaxVertices);
    localparam int UsedBits    = VnumBits + 1;
    localparam int KeyBits     = 3 * IndexBits;

    localparam logic [IndexBits-1:0] CountLimit = {1'b0, {(IndexBits-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_ADD_POS  = 2'd0,
        OP_ADD_TEX  = 2'd1,
        OP_ADD_NORM = 2'd2,
        OP_CORNER   = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [IndexBits-1:0] n;
        logic signed [IndexBits-1:0] t;
        logic signed [IndexBits-1:0] p;
    } key_t;

    function automatic logic [IndexBits-1:0] sat_inc(input logic [IndexBits-1:0] c);
        return (c < CountLimit) ? c + 1'b1 : CountLimit;
    endfunction

    // Positive raw is 1-based, negative counts back from the list size, zero is absent.
    function automatic logic signed [IndexBits-1:0] resolve(
        input logic signed [IndexBits-1:0] raw,
        input logic        [IndexBits-1:0] count
    );
        logic signed [IndexBits-1:0] r;
        r = '1;
        if (raw > 0) r = raw - 1;
        else if (raw < 0) r = $signed(count + $unsigned(raw));
        return r;
    endfunction

    function automatic logic in_range(
        input logic signed [IndexBits-1:0] idx,
        input logic        [IndexBits-1:0] count
    );
        return (idx >= 0) && ($unsigned(idx) < count);
    endfunction

endpackage

/* src/face_vertex_dedup_indexer.sv */
// Top level: corner resolution, fan triangulation and key table search.
//
// Input channel s_*: one request per event. tuser carries op and starts_face,
// tdata the three raw indices. Count events and the first two corners of a
// face produce nothing; each later corner produces three results (first,
// previous, this corner), the third marked by m_tlast.
// A lookup scans the key table linearly, one entry per cycle through the
// table RAM's single read port (registered read), and stops early on a hit;
// a corner runs its three lookups one after another, while count events
// need no lookup. A missing key is appended in the cycle the scan ends; a
// full table reports table_full and inserts nothing.
// One output register holds each result; when the receiver stalls, the block
// waits with the next finished lookup until the register is taken, and the
// input side stays closed until the corner is done.
// Reset clears counts, corner state and the fill count; the table needs no
// clearing pass, since only entries below the fill count are read.
module face_vertex_dedup_indexer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_raw[31:0], tex_raw[63:32], norm_raw[95:64]
    input  logic [95:0]  s_tdata,
    // op[1:0], starts_face[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_number[11:0], is_new[12], pos_index[44:13], pos_ok[45],
    // tex_index[77:46], tex_ok[78], norm_index[110:79], norm_ok[111],
    // table_full[112], zero fill [119:113]
    output logic [119:0] m_tdata,
    output logic         m_tlast
);
    localparam int IB = fvdi_pkg::IndexBits;
    localparam int VB = fvdi_pkg::VnumBits;
    localparam int UB = fvdi_pkg::UsedBits;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [IB-1:0] pcnt_reg, tcnt_reg, ncnt_reg;
    logic [1:0]    ord_reg;
    fvdi_pkg::key_t first_reg, prev_reg, cur_reg;
    logic [1:0]    lk_reg;
    logic [UB-1:0] used_reg, issue_reg;
    logic          pend_reg;
    logic [VB-1:0] pidx_reg;
    logic [VB-1:0] num_reg;
    logic          new_reg, full_reg;

    logic          m_valid_reg;
    logic [119:0]  m_data_reg;
    logic          m_last_reg;

    fvdi_pkg::key_t in_key, lk_key;
    logic [fvdi_pkg::KeyBits-1:0] rdata;
    logic          we, match, s_acc, out_free;
    fvdi_pkg::op_t op;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign op       = fvdi_pkg::op_t'(s_tuser[1:0]);
    assign out_free = !m_valid_reg || m_tready;

    assign in_key.p = fvdi_pkg::resolve(s_tdata[31:0],  pcnt_reg);
    assign in_key.t = fvdi_pkg::resolve(s_tdata[63:32], tcnt_reg);
    assign in_key.n = fvdi_pkg::resolve(s_tdata[95:64], ncnt_reg);

    always_comb begin
        unique case (lk_reg)
            2'd0:    lk_key = first_reg;
            2'd1:    lk_key = prev_reg;
            default: lk_key = cur_reg;
        endcase
    end

    assign match = pend_reg && (rdata == lk_key);
    assign we = (state_reg == ST_SCAN) && !match && (issue_reg == used_reg)
                && (used_reg < UB'(fvdi_pkg::MaxVertices));

    fvdi_ram #(.Width(fvdi_pkg::KeyBits), .Depth(fvdi_pkg::MaxVertices)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (used_reg[VB-1:0]),
        .wdata (lk_key),
        .raddr (issue_reg[VB-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc && op == fvdi_pkg::OP_CORNER && !s_tuser[2]
                         && ord_reg >= 2'd2) state_next = ST_SCAN;
            ST_SCAN: if (match || issue_reg == used_reg) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = (lk_reg == 2'd2) ? ST_IDLE : ST_SCAN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pcnt_reg    <= '0;
            tcnt_reg    <= '0;
            ncnt_reg    <= '0;
            ord_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // in ST_FIN the output register is reloaded below whenever it frees up
            if (m_valid_reg && m_tready && state_reg != ST_FIN) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        unique case (op)
                            fvdi_pkg::OP_ADD_POS:  pcnt_reg <= fvdi_pkg::sat_inc(pcnt_reg);
                            fvdi_pkg::OP_ADD_TEX:  tcnt_reg <= fvdi_pkg::sat_inc(tcnt_reg);
                            fvdi_pkg::OP_ADD_NORM: ncnt_reg <= fvdi_pkg::sat_inc(ncnt_reg);
                            default: begin
                                if (s_tuser[2] || ord_reg == 2'd0) begin
                                    first_reg <= in_key;
                                    ord_reg   <= 2'd1;
                                end else if (ord_reg == 2'd1) begin
                                    prev_reg <= in_key;
                                    ord_reg  <= 2'd2;
                                end else begin
                                    cur_reg   <= in_key;
                                    ord_reg   <= 2'd3;
                                    lk_reg    <= 2'd0;
                                    issue_reg <= '0;
                                    pend_reg  <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (match) begin
                        num_reg  <= pidx_reg;
                        new_reg  <= 1'b0;
                        full_reg <= 1'b0;
                        pend_reg <= 1'b0;
                    end else if (issue_reg != used_reg) begin
                        // advance the scan; compare lands next cycle
                        pend_reg  <= 1'b1;
                        pidx_reg  <= issue_reg[VB-1:0];
                        issue_reg <= issue_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                        if (we) begin
                            num_reg  <= used_reg[VB-1:0];
                            new_reg  <= 1'b1;
                            full_reg <= 1'b0;
                            used_reg <= used_reg + 1'b1;
                        end else begin
                            num_reg  <= '0;
                            new_reg  <= 1'b0;
                            full_reg <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= (lk_reg == 2'd2);
                        m_data_reg  <= {7'd0, full_reg,
                            fvdi_pkg::in_range(lk_key.n, ncnt_reg), lk_key.n,
                            fvdi_pkg::in_range(lk_key.t, tcnt_reg), lk_key.t,
                            fvdi_pkg::in_range(lk_key.p, pcnt_reg), lk_key.p,
                            new_reg, num_reg};
                        if (lk_reg == 2'd2) prev_reg <= cur_reg;
                        lk_reg    <= lk_reg + 1'b1;
                        issue_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UB'(fvdi_pkg::MaxVertices))
        else $error("fill count beyond table depth");
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("fill count jumped");
    a_new_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !(new_reg && full_reg))
        else $error("insert and full at once");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= used_reg))
        else $error("scan ran past fill count");
endmodule

/* src/fvdi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module fvdi_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* test/tb_top.sv */
// Testbench for face_vertex_dedup_indexer: fan triangulation and key dedup against a local model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // first field sits in the top bits, matching {m_tdata[112:0], m_tlast}
    typedef struct packed {
        logic                                  full;
        logic                                  n_ok;
        logic signed [fvdi_pkg::IndexBits-1:0] n;
        logic                                  t_ok;
        logic signed [fvdi_pkg::IndexBits-1:0] t;
        logic                                  p_ok;
        logic signed [fvdi_pkg::IndexBits-1:0] p;
        logic                                  is_new;
        logic [fvdi_pkg::VnumBits-1:0]         vnum;
        logic                                  last;
    } lookup_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         m_tlast;

    face_vertex_dedup_indexer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // model state
    logic [fvdi_pkg::IndexBits-1:0] pos_cnt, tex_cnt, norm_cnt;
    int                             corner_ord;
    fvdi_pkg::key_t                 fan_first, fan_prev;
    fvdi_pkg::key_t                 vtx_keys[fvdi_pkg::MaxVertices];
    int                             vtx_used;
    lookup_t                        lookups_due[$];

    int snd_idle_pct, rcv_idle_pct, rcv_hold;
    int mismatches, items_sent, results_seen, dup_hits;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [fvdi_pkg::IndexBits-1:0] to_index(
        input logic signed [fvdi_pkg::IndexBits-1:0] raw,
        input logic [fvdi_pkg::IndexBits-1:0] cnt);
        if (raw > 0) return raw - 1;
        if (raw < 0) return $signed(cnt + $unsigned(raw));
        return -1;
    endfunction

    function automatic logic idx_ok(
        input logic signed [fvdi_pkg::IndexBits-1:0] idx,
        input logic [fvdi_pkg::IndexBits-1:0] cnt);
        return (idx >= 0) && ($unsigned(idx) < cnt);
    endfunction

    function automatic logic [fvdi_pkg::IndexBits-1:0] bump(
        input logic [fvdi_pkg::IndexBits-1:0] c);
        return (c < fvdi_pkg::CountLimit) ? c + 1'b1 : fvdi_pkg::CountLimit;
    endfunction

    task automatic find_vertex(input fvdi_pkg::key_t k, input logic is_last);
        lookup_t r;
        int      i;
        r = '0;
        r.vnum = '0;
        for (i = 0; i < vtx_used; i++)
            if (vtx_keys[i] == k) break;
        if (i < vtx_used) begin
            r.vnum = i[fvdi_pkg::VnumBits-1:0];
            dup_hits++;
        end else if (vtx_used < fvdi_pkg::MaxVertices) begin
            vtx_keys[vtx_used] = k;
            r.vnum = vtx_used[fvdi_pkg::VnumBits-1:0];
            r.is_new = 1'b1;
            vtx_used++;
        end else begin
            r.full = 1'b1;
        end
        r.p = k.p; r.p_ok = idx_ok(k.p, pos_cnt);
        r.t = k.t; r.t_ok = idx_ok(k.t, tex_cnt);
        r.n = k.n; r.n_ok = idx_ok(k.n, norm_cnt);
        r.last = is_last;
        lookups_due = {lookups_due, r};
    endtask

    task automatic predict_event(input fvdi_pkg::op_t op, input logic sf,
                                 input logic [95:0] raw);
        fvdi_pkg::key_t k;
        case (op)
            fvdi_pkg::OP_ADD_POS:  pos_cnt  = bump(pos_cnt);
            fvdi_pkg::OP_ADD_TEX:  tex_cnt  = bump(tex_cnt);
            fvdi_pkg::OP_ADD_NORM: norm_cnt = bump(norm_cnt);
            default: begin
                k.p = to_index(raw[31:0], pos_cnt);
                k.t = to_index(raw[63:32], tex_cnt);
                k.n = to_index(raw[95:64], norm_cnt);
                if (sf || corner_ord == 0) begin
                    fan_first = k;
                    corner_ord = 1;
                end else if (corner_ord == 1) begin
                    fan_prev = k;
                    corner_ord = 2;
                end else begin
                    find_vertex(fan_first, 1'b0);
                    find_vertex(fan_prev, 1'b0);
                    find_vertex(k, 1'b1);
                    fan_prev = k;
                    corner_ord = 3;
                end
            end
        endcase
    endtask

    // Leaves tvalid high after acceptance; a drain, or an idle gap in the next call, lowers it.
    task automatic send_event(input fvdi_pkg::op_t op, input logic sf,
                              input logic [31:0] p, input logic [31:0] t, input logic [31:0] n);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sf, op};
        s_tdata  <= {n, t, p};
        do @(posedge aclk); while (!s_tready);
        predict_event(op, sf, {n, t, p});
        items_sent++;
    endtask

    task automatic corner(input logic sf, input logic [31:0] p, input logic [31:0] t,
                          input logic [31:0] n);
        send_event(fvdi_pkg::OP_CORNER, sf, p, t, n);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_raw(input logic [fvdi_pkg::IndexBits-1:0] cnt);
        case ($urandom_range(11))
            0:       return 32'd0;
            1, 2, 3: return $urandom_range(1, cnt + 2);
            4, 5:    return -$urandom_range(1, cnt + 1);
            6:       return $urandom;
            7:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    task automatic random_event(input int face_len, inout int pos_in_face);
        int  sel;
        sel = $urandom_range(99);
        if (sel < 8)
            send_event(fvdi_pkg::op_t'($urandom_range(2)), 1'($urandom_range(1)),
                       $urandom, $urandom, $urandom);
        else if (sel < 12)
            // broken sequence: corner that may or may not open a face
            corner(1'($urandom_range(1)), pick_raw(pos_cnt), pick_raw(tex_cnt),
                   pick_raw(norm_cnt));
        else begin
            corner(pos_in_face == 0, pick_raw(pos_cnt), pick_raw(tex_cnt), pick_raw(norm_cnt));
            pos_in_face = (pos_in_face + 1 >= face_len) ? 0 : pos_in_face + 1;
        end
    endtask

    task automatic test_directed;
        send_event(fvdi_pkg::OP_ADD_POS, 1'b0, '0, '0, '0);
        send_event(fvdi_pkg::OP_ADD_POS, 1'b0, '0, '0, '0);
        send_event(fvdi_pkg::OP_ADD_TEX, 1'b0, '0, '0, '0);
        send_event(fvdi_pkg::OP_ADD_NORM, 1'b1, '0, '0, '0);
        // corner without a face opens one
        corner(1'b0, 32'd1, 32'd1, 32'd1);
        corner(1'b0, 32'd2, 32'd0, 32'hffff_ffff);
        corner(1'b0, 32'hffff_ffff, 32'hffff_fffe, 32'd0);
        corner(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'd5);
        // counts changing inside a face
        send_event(fvdi_pkg::OP_ADD_POS, 1'b0, '0, '0, '0);
        corner(1'b0, 32'd3, 32'd1, 32'd1);
        // repeated face hits existing keys
        corner(1'b1, 32'd1, 32'd1, 32'd1);
        corner(1'b0, 32'd2, 32'd0, 32'hffff_ffff);
        corner(1'b0, 32'd3, 32'd1, 32'd1);
        corner(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        corner(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        corner(1'b0, 32'hffff_fff0, 32'd9, 32'h7fff_ffff);
        corner(1'b0, 32'd0, 32'd0, 32'd0);
        corner(1'b1, 32'd0, 32'd0, 32'd0);
        drain_results();
    endtask

    task automatic test_random(input int n_items, input int face_base);
        int pos_in_face, face_len;
        pos_in_face = 0;
        face_len = face_base;
        repeat (n_items) begin
            if (pos_in_face == 0) face_len = $urandom_range(3, face_base + 3);
            random_event(face_len, pos_in_face);
        end
    endtask

    task automatic test_receiver_stall;
        int pif;
        pif = 0;
        rcv_hold = 400;
        repeat (12) random_event(6, pif);
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (rcv_hold > 0) begin
            rcv_hold = rcv_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        lookup_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[112:0], m_tlast};
            results_seen++;
            if (lookups_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = lookups_due.pop_front();
                if (got.vnum !== want.vnum || got.is_new !== want.is_new ||
                    got.p !== want.p || got.p_ok !== want.p_ok ||
                    got.t !== want.t || got.t_ok !== want.t_ok ||
                    got.n !== want.n || got.n_ok !== want.n_ok ||
                    got.full !== want.full || got.last !== want.last ||
                    m_tdata[119:113] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        pos_cnt = '0; tex_cnt = '0; norm_cnt = '0;
        corner_ord = 0; vtx_used = 0; rcv_hold = 0;
        fan_first = '0; fan_prev = '0;
        mismatches = 0; items_sent = 0; results_seen = 0; dup_hits = 0;
        snd_idle_pct = 0; rcv_idle_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        snd_idle_pct = 21; rcv_idle_pct = 49;
        test_random(100, 3);
        test_receiver_stall();
        snd_idle_pct = 49; rcv_idle_pct = 21;
        test_random(100, 5);
        snd_idle_pct = 0; rcv_idle_pct = 0;
        test_random(100, 2);
        drain_results();
        repeat (3 * vtx_used + 20) @(posedge aclk);

        if (lookups_due.size() != 0) mismatches++;
        $display("covered %0d events, %0d lookups, %0d keys, %0d repeat hits",
                 items_sent, results_seen, vtx_used, dup_hits);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
